FILE: sv/tmbc_pkg.sv
package tmbc_pkg;

    // map size default
    localparam int MAP_TILES_DEF = 4096;

    // field widths
    localparam int CMD_W   = 3;
    localparam int POS_W   = 12;
    localparam int SIZE_W  = 9;
    localparam int TIDX_W  = 12;
    localparam int TS_W    = 7;
    localparam int TPR_W   = 13;
    localparam int MW_W    = 12;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILE_SIZE     = 2'd0,
        CFG_TILES_PER_ROW = 2'd1,
        CFG_MAP_WIDTH_PX  = 2'd2
    } t_cfg_idx;

    localparam logic [TS_W-1:0]  TS_RST  = 7'd16;
    localparam logic [TPR_W-1:0] TPR_RST = 13'd64;
    localparam logic [MW_W-1:0]  MW_RST  = 12'd1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 3'd0,
        CMD_RIGHT = 3'd1,
        CMD_LEFT  = 3'd2,
        CMD_DOWN  = 3'd3,
        CMD_UP    = 3'd4,
        CMD_FALLS = 3'd5
    } t_cmd;

    // coordinate math: one bit more than a position covers pos + size
    localparam int VAL_W   = POS_W + 1;
    localparam int QMAG_W  = POS_W;          // quotient magnitude bits
    localparam int DIV_STEPS = QMAG_W;
    localparam int CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int MUL_W   = VAL_W + 1;      // signed multiplier operand
    localparam int IDX_W   = 27;             // signed linear tile index
    localparam int GAP_W   = 15;             // down snap arithmetic

    localparam int SNAP_REACH = 4;
    localparam int POS_MIN    = -2048;
    localparam int POS_MAX    = 2047;

endpackage

FILE: sv/tile_map_box_collision.sv
// Tile map box collision. A one-bit solid map (MAP_TILES entries, row * tiles_per_row
// + column) is written by tile-write beats and probed by box queries: right, left,
// up, down (with a snap of y onto the tile top) and falls (is some tile below empty).
// After reset the block runs a clearing pass over the map, one entry per cycle,
// and stalls its input meanwhile; configuration writes are taken at any time.
// One item is in work at a time. A tile write, an unused code, or a query decided
// by a screen edge goes from accept straight to the done state. Any other query runs
// three tile-coordinate divides on one shared restoring divider, one quotient bit
// per cycle, then forms the starting map index on the shared multiplier (down first
// forms and checks the snap and stops there if out of reach), then walks the tiles
// one per cycle through the registered map read port, stopping at the first tile
// that decides the answer or after the last one. The result waits in an output
// register, so the next beat is accepted while it is held.
module tile_map_box_collision #(
    parameter int MAP_TILES = tmbc_pkg::MAP_TILES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [tmbc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tmbc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [tmbc_pkg::CMD_W-1:0]        i_cmd,
    input  logic signed [tmbc_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [tmbc_pkg::POS_W-1:0] i_pos_y,
    input  logic [tmbc_pkg::SIZE_W-1:0]       i_size_x,
    input  logic [tmbc_pkg::SIZE_W-1:0]       i_size_y,
    input  logic [tmbc_pkg::TIDX_W-1:0]       i_tile_index,
    input  logic                              i_tile_solid,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_hit,
    output logic signed [tmbc_pkg::POS_W-1:0] o_new_pos_y
);
    import tmbc_pkg::*;

    localparam int ADDR_W = $clog2(MAP_TILES);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_SNAP,
        S_CHK,
        S_BASE,
        S_IDX,
        S_WALK,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration registers
    logic [TS_W-1:0]  r_ts;
    logic [TPR_W-1:0] r_tpr;
    logic [MW_W-1:0]  r_mw;

    // item context
    t_cmd                     r_cmd;
    logic signed [POS_W-1:0]  r_py;
    logic [SIZE_W-1:0]        r_sy;
    logic                     r_vert;      // walk goes down a column
    logic                     r_res_hit;
    logic signed [POS_W-1:0]  r_res_y;
    logic signed [POS_W-1:0]  r_snap;

    // slot 0: fixed coordinate, slot 1: first of range, slot 2: last of range;
    // each holds a pixel value until the divider turns it into a tile number
    logic signed [VAL_W-1:0]  r_slot [3];
    logic [1:0]               r_dsel;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_dneg;
    logic [QMAG_W-1:0]        r_dmag;      // dividend shifting out, quotient in
    logic [TS_W-1:0]          r_rem;

    // shared multiplier result and walk
    logic signed [IDX_W-1:0]  r_prod;
    logic signed [IDX_W-1:0]  r_idx;
    logic signed [VAL_W-1:0]  r_cur;
    logic                     r_pend;
    logic                     r_pend_ok;
    logic                     r_pend_last;

    // map
    logic                     r_map [MAP_TILES];
    logic                     r_rd;
    logic [ADDR_W-1:0]        r_clr;

    // output register
    logic                     r_out_valid;
    logic                     r_out_hit;
    logic signed [POS_W-1:0]  r_out_y;

    // ------------------------------------------------------------------
    // beat decode
    // ------------------------------------------------------------------
    logic                     accept;
    logic [TS_W-1:0]          ts_eff;
    logic signed [VAL_W-1:0]  px_v, py_v, sx_v, sy_v;
    logic signed [VAL_W-1:0]  px_end, py_end, py_below;
    logic signed [VAL_W:0]    px_reach;
    logic                     right_out;
    logic                     tidx_ok;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign ts_eff   = (r_ts == '0) ? TS_W'(1) : r_ts;   // zero tile size acts as one

    assign px_v     = {i_pos_x[POS_W-1], i_pos_x};
    assign py_v     = {i_pos_y[POS_W-1], i_pos_y};
    assign sx_v     = {{(VAL_W-SIZE_W){1'b0}}, i_size_x};
    assign sy_v     = {{(VAL_W-SIZE_W){1'b0}}, i_size_y};
    assign px_end   = px_v + sx_v - VAL_W'(1);
    assign py_end   = py_v + sy_v - VAL_W'(1);
    assign py_below = py_v + sy_v + VAL_W'(1);
    assign px_reach = {px_v[VAL_W-1], px_v} + {1'b0, sx_v};
    assign right_out = px_reach > $signed({{(VAL_W+1-MW_W){1'b0}}, r_mw});
    assign tidx_ok  = 32'(i_tile_index) < 32'(MAP_TILES);

    // ------------------------------------------------------------------
    // shared divider step: restoring, one quotient bit per cycle
    // ------------------------------------------------------------------
    logic [TS_W:0]            div_trial;
    logic                     div_ge;
    logic [TS_W:0]            n_rem;
    logic [QMAG_W-1:0]        n_quot;
    logic signed [VAL_W-1:0]  div_src;
    logic signed [VAL_W-1:0]  div_neg_src;

    assign div_src     = r_slot[r_dsel];
    assign div_neg_src = -div_src;
    assign div_trial   = {r_rem, r_dmag[QMAG_W-1]};
    assign div_ge      = div_trial >= {1'b0, ts_eff};
    assign n_rem       = div_ge ? (div_trial - {1'b0, ts_eff}) : div_trial;
    assign n_quot      = {r_dmag[QMAG_W-2:0], div_ge};

    // ------------------------------------------------------------------
    // shared multiplier: ts * row for the snap, row * tiles_per_row for the index
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0]   fix, lo, hi, row0, col0;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;

    assign fix  = r_slot[0];
    assign lo   = r_slot[1];
    assign hi   = r_slot[2];
    assign row0 = r_vert ? lo : fix;
    assign col0 = r_vert ? fix : lo;

    assign mul_a = (r_state == S_SNAP) ? {fix[VAL_W-1], fix} : {row0[VAL_W-1], row0};
    assign mul_b = (r_state == S_SNAP) ? $signed({{(MUL_W-TS_W){1'b0}}, ts_eff})
                                       : $signed({{(MUL_W-TPR_W){1'b0}}, r_tpr});
    assign mul_p = mul_a * mul_b;

    // down: bottom must be within reach of the tile top, snapped y saturates
    logic signed [GAP_W-1:0]  gap, snap_v;
    logic signed [POS_W-1:0]  snap_sat;

    assign gap    = GAP_W'(r_py) + GAP_W'(r_sy) - GAP_W'(r_prod);
    assign snap_v = GAP_W'(r_prod) - GAP_W'(r_sy);

    always_comb begin
        if (snap_v < $signed(GAP_W'(POS_MIN))) begin
            snap_sat = POS_W'(POS_MIN);
        end else if (snap_v > $signed(GAP_W'(POS_MAX))) begin
            snap_sat = POS_W'(POS_MAX);
        end else begin
            snap_sat = snap_v[POS_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // tile walk
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0]  w_row, w_col;
    logic                     tile_ok;
    logic                     issue;
    logic [IDX_W-1:0]         w_step;
    logic                     solid;
    logic                     decide;

    assign w_row   = r_vert ? r_cur : fix;
    assign w_col   = r_vert ? fix : r_cur;
    // outside the map reads as empty
    assign tile_ok = !w_row[VAL_W-1] && !w_col[VAL_W-1]
                     && ($unsigned(w_col) < r_tpr)
                     && (r_idx < $signed(IDX_W'(MAP_TILES)));
    assign issue   = r_cur <= hi;
    assign w_step  = r_vert ? IDX_W'(r_tpr) : IDX_W'(1);
    assign solid   = r_pend_ok & r_rd;
    // falls looks for an empty tile, the others for a solid one
    assign decide  = (r_cmd == CMD_FALLS) ? !solid : solid;

    // ------------------------------------------------------------------
    // map memory: one write port shared by the clearing pass and tile writes
    // ------------------------------------------------------------------
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic              mem_wd;

    assign mem_we = (r_state == S_CLEAR)
                    || (accept && (i_cmd == CMD_WRITE) && tidx_ok);
    assign mem_wa = (r_state == S_CLEAR) ? r_clr : ADDR_W'(i_tile_index);
    assign mem_wd = (r_state == S_CLEAR) ? 1'b0 : i_tile_solid;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_wa] <= mem_wd;
        end
        r_rd <= r_map[ADDR_W'(r_idx)];
    end

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts  <= TS_RST;
            r_tpr <= TPR_RST;
            r_mw  <= MW_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TILE_SIZE:     r_ts  <= i_cfg_data[TS_W-1:0];
                CFG_TILES_PER_ROW: r_tpr <= i_cfg_data[TPR_W-1:0];
                CFG_MAP_WIDTH_PX:  r_mw  <= i_cfg_data[MW_W-1:0];
                default: ;         // unused index
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_dsel      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // result taken downstream
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == ADDR_W'(MAP_TILES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (accept) begin
                        r_cmd     <= t_cmd'(i_cmd);
                        r_py      <= i_pos_y;
                        r_sy      <= i_size_y;
                        r_res_y   <= i_pos_y;
                        r_res_hit <= 1'b0;
                        r_dsel    <= '0;
                        r_cnt     <= '0;
                        unique case (t_cmd'(i_cmd))
                            CMD_RIGHT: begin
                                if (right_out) begin
                                    r_res_hit <= 1'b1;
                                    r_state   <= S_DONE;
                                end else begin
                                    r_slot[0] <= px_end;
                                    r_slot[1] <= py_v;
                                    r_slot[2] <= py_end;
                                    r_vert    <= 1'b1;
                                    r_state   <= S_DIV;
                                end
                            end
                            CMD_LEFT: begin
                                if (px_v[VAL_W-1]) begin
                                    r_res_hit <= 1'b1;
                                    r_state   <= S_DONE;
                                end else begin
                                    r_slot[0] <= px_v;
                                    r_slot[1] <= py_v;
                                    r_slot[2] <= py_end;
                                    r_vert    <= 1'b1;
                                    r_state   <= S_DIV;
                                end
                            end
                            CMD_UP: begin
                                if (py_v[VAL_W-1]) begin
                                    r_res_hit <= 1'b1;
                                    r_state   <= S_DONE;
                                end else begin
                                    r_slot[0] <= py_v;
                                    r_slot[1] <= px_v;
                                    r_slot[2] <= px_end;
                                    r_vert    <= 1'b0;
                                    r_state   <= S_DIV;
                                end
                            end
                            CMD_DOWN: begin
                                r_slot[0] <= py_end;
                                r_slot[1] <= px_v;
                                r_slot[2] <= px_end;
                                r_vert    <= 1'b0;
                                r_state   <= S_DIV;
                            end
                            CMD_FALLS: begin
                                r_slot[0] <= py_below;
                                r_slot[1] <= px_v;
                                r_slot[2] <= px_end;
                                r_vert    <= 1'b0;
                                r_state   <= S_DIV;
                            end
                            default: begin
                                // tile write goes to the map port, unused codes do nothing
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end

                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_dneg <= div_src[VAL_W-1];
                        r_dmag <= div_src[VAL_W-1] ? div_neg_src[QMAG_W-1:0]
                                                   : div_src[QMAG_W-1:0];
                        r_rem  <= '0;
                        r_cnt  <= CNT_W'(1);
                    end else begin
                        r_rem  <= n_rem[TS_W-1:0];
                        r_dmag <= n_quot;
                        if (r_cnt == CNT_W'(DIV_STEPS)) begin
                            // truncation toward zero: divide magnitudes, restore sign
                            r_slot[r_dsel] <= r_dneg ? -$signed({1'b0, n_quot})
                                                     : $signed({1'b0, n_quot});
                            r_cnt <= '0;
                            if (r_dsel == 2'd2) begin
                                r_state <= (r_cmd == CMD_DOWN) ? S_SNAP : S_BASE;
                            end else begin
                                r_dsel <= r_dsel + 2'd1;
                            end
                        end else begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                    end
                end

                S_SNAP: begin
                    r_prod  <= IDX_W'(mul_p);    // ts * bottom row
                    r_state <= S_CHK;
                end

                S_CHK: begin
                    if (gap <= $signed(GAP_W'(SNAP_REACH))) begin
                        r_snap  <= snap_sat;
                        r_state <= S_BASE;
                    end else begin
                        r_state <= S_DONE;
                    end
                end

                S_BASE: begin
                    if (lo > hi) begin
                        // empty range: no tile looked at
                        r_state <= S_DONE;
                    end else begin
                        r_prod  <= IDX_W'(mul_p);  // first row * tiles_per_row
                        r_state <= S_IDX;
                    end
                end

                S_IDX: begin
                    r_idx   <= r_prod + IDX_W'(col0);
                    r_cur   <= lo;
                    r_pend  <= 1'b0;
                    r_state <= S_WALK;
                end

                S_WALK: begin
                    // issue the next tile read
                    if (issue) begin
                        r_pend      <= 1'b1;
                        r_pend_ok   <= tile_ok;
                        r_pend_last <= (r_cur == hi);
                        r_cur       <= r_cur + VAL_W'(1);
                        r_idx       <= r_idx + w_step;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    // check the tile read last cycle
                    if (r_pend) begin
                        if (decide) begin
                            r_res_hit <= 1'b1;
                            if (r_cmd == CMD_DOWN) begin
                                r_res_y <= r_snap;
                            end
                            r_pend  <= 1'b0;
                            r_state <= S_DONE;
                        end else if (r_pend_last) begin
                            r_pend  <= 1'b0;
                            r_state <= S_DONE;
                        end
                    end
                end

                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_res_hit;
                        r_out_y     <= r_res_y;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_new_pos_y = r_out_y;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_in_stall)
        else $error("beat accepted during map clearing pass");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside the done state");

    a_pend_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_WALK))
        else $error("tile read pending outside the walk");

    a_div_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ((r_cnt <= CNT_W'(DIV_STEPS)) && (r_dsel <= 2'd2)))
        else $error("divider sequencer out of range");

endmodule

FILE: bench/tb_tile_map_box_collision.sv
`timescale 1ns / 1ps
module tb_tile_map_box_collision;
    import tmbc_pkg::*;

    localparam int MAP_TILES        = MAP_TILES_DEF;
    // worst item: three divides, index setup and a 511-tile walk, plus stalls, taken 4x
    localparam int RUN_LIMIT_CYCLES = 4_500_000;
    localparam int DRAIN_CYCLES     = 600;
    localparam int RAND_PHASES      = 12;
    localparam int ITEMS_PER_PHASE  = 133;
    localparam int MAX_SIZE         = (1 << SIZE_W) - 1;
    localparam int MAX_TILE_INDEX   = (1 << TIDX_W) - 1;
    localparam int MAX_CMD_CODE     = (1 << CMD_W) - 1;

    // codes the block leaves unused
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [SIZE_W-1:0]       size_x;
        logic [SIZE_W-1:0]       size_y;
        logic [TIDX_W-1:0]       tile_index;
        logic                    tile_solid;
    } box_beat_t;

    typedef struct packed {
        logic                    hit;
        logic signed [POS_W-1:0] new_pos_y;
    } box_answer_t;

    // dut connections, all inputs known from time zero
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = CFG_TILE_SIZE;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_stall;
    logic [CMD_W-1:0]        i_cmd        = CMD_WRITE;
    logic signed [POS_W-1:0] i_pos_x      = '0;
    logic signed [POS_W-1:0] i_pos_y      = '0;
    logic [SIZE_W-1:0]       i_size_x     = '0;
    logic [SIZE_W-1:0]       i_size_y     = '0;
    logic [TIDX_W-1:0]       i_tile_index = '0;
    logic                    i_tile_solid = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_stall  = 1'b0;
    logic                    o_hit;
    logic signed [POS_W-1:0] o_new_pos_y;

    // shadow of the block: solid flags and map geometry
    bit solid_map_q [MAP_TILES];
    int tile_size_q     = TS_RST;
    int tiles_per_row_q = TPR_RST;
    int map_width_q     = MW_RST;

    // answers still owed by the block, oldest first
    box_answer_t expected_answers [$];

    int beats_sent      = 0;
    int writes_sent     = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int hits_predicted  = 0;
    int snaps_predicted = 0;
    int geometry_count  = 0;

    // percent of cycles each side holds off
    int tx_idle_pct = 11;
    int rx_idle_pct = 48;

    // tile window that random writes and queries cluster on
    int win_col = 0;
    int win_row = 0;

    tile_map_box_collision #(
        .MAP_TILES(MAP_TILES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_size_x    (i_size_x),
        .i_size_y    (i_size_y),
        .i_tile_index(i_tile_index),
        .i_tile_solid(i_tile_solid),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_hit       (o_hit),
        .o_new_pos_y (o_new_pos_y)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // collision predictor
    // ---------------------------------------------------------------

    // a tile size of zero behaves as one
    function automatic int effective_tile();
        return (tile_size_q == 0) ? 1 : tile_size_q;
    endfunction

    // tiles off the map (negative, past the row, past the store) read empty
    function automatic bit tile_is_solid(input int col, input int row);
        longint lin;
        if (col < 0 || row < 0 || col >= tiles_per_row_q) return 1'b0;
        lin = longint'(row) * tiles_per_row_q + col;
        if (lin >= MAP_TILES) return 1'b0;
        return solid_map_q[int'(lin)];
    endfunction

    // an inverted range walks nothing
    function automatic bit column_has_solid(input int col, input int r_first, input int r_last);
        int r;
        for (r = r_first; r <= r_last; r++)
            if (tile_is_solid(col, r)) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit row_has_solid(input int row, input int c_first, input int c_last);
        int c;
        for (c = c_first; c <= c_last; c++)
            if (tile_is_solid(c, row)) return 1'b1;
        return 1'b0;
    endfunction

    // answer for one accepted beat; tile writes update the shadow map
    function automatic box_answer_t predict_answer(input box_beat_t b);
        box_answer_t ans;
        int ts, px, py, sx, sy;
        int c0, c1, r0, r1, rb, snap, c;
        ts = effective_tile();
        px = $signed(b.pos_x);
        py = $signed(b.pos_y);
        sx = b.size_x;
        sy = b.size_y;
        // integer division truncates toward zero, as the block does
        c0 = px / ts;
        c1 = (px + sx - 1) / ts;
        r0 = py / ts;
        r1 = (py + sy - 1) / ts;
        ans.hit = 1'b0;
        ans.new_pos_y = b.pos_y;
        case (b.cmd)
            CMD_WRITE: begin
                if (b.tile_index < MAP_TILES) solid_map_q[b.tile_index] = b.tile_solid;
            end
            CMD_RIGHT: ans.hit = (px + sx > map_width_q) || column_has_solid(c1, r0, r1);
            CMD_LEFT:  ans.hit = (px < 0) || column_has_solid(c0, r0, r1);
            CMD_UP:    ans.hit = (py < 0) || row_has_solid(r0, c0, c1);
            CMD_DOWN: begin
                // only a bottom edge within reach of the tile top snaps
                if (py - ts * r1 + sy <= SNAP_REACH && row_has_solid(r1, c0, c1)) begin
                    snap = ts * r1 - sy;
                    if (snap < POS_MIN) snap = POS_MIN;
                    if (snap > POS_MAX) snap = POS_MAX;
                    ans.new_pos_y = POS_W'(snap);
                    ans.hit = 1'b1;
                    snaps_predicted++;
                end
            end
            CMD_FALLS: begin
                // row just under the bottom edge, any empty tile means a fall
                rb = (py + sy + 1) / ts;
                for (c = c0; c <= c1; c++)
                    if (!tile_is_solid(c, rb)) ans.hit = 1'b1;
            end
            default: ;
        endcase
        if (ans.hit) hits_predicted++;
        return ans;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic box_beat_t make_beat(
        input logic [CMD_W-1:0] cmd,
        input int               px,
        input int               py,
        input int               sx,
        input int               sy,
        input int               tidx,
        input bit               solid
    );
        box_beat_t b;
        b.cmd        = cmd;
        b.pos_x      = POS_W'(px);
        b.pos_y      = POS_W'(py);
        b.size_x     = SIZE_W'(sx);
        b.size_y     = SIZE_W'(sy);
        b.tile_index = TIDX_W'(tidx);
        b.tile_solid = solid;
        return b;
    endfunction

    function automatic int clamp_pos(input int v);
        if (v < POS_MIN) return POS_MIN;
        if (v > POS_MAX) return POS_MAX;
        return v;
    endfunction

    // enters and leaves on a rising edge; valid stays high between back-to-back beats
    task automatic send_beat(input box_beat_t b);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= b.cmd;
        i_pos_x      <= b.pos_x;
        i_pos_y      <= b.pos_y;
        i_size_x     <= b.size_x;
        i_size_y     <= b.size_y;
        i_tile_index <= b.tile_index;
        i_tile_solid <= b.tile_solid;
        // hold the payload until the block takes it
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        expected_answers.push_back(predict_answer(b));
        beats_sent++;
        if (b.cmd == CMD_WRITE) writes_sent++;
    endtask

    // stop sending and let every owed answer come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write all three registers back to back; the block is idle here
    task automatic set_map_geometry(input int ts, input int tpr, input int mw);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TILE_SIZE;
        i_cfg_data  <= CFG_DATA_W'(ts);
        @(posedge i_clk);
        i_cfg_index <= CFG_TILES_PER_ROW;
        i_cfg_data  <= CFG_DATA_W'(tpr);
        @(posedge i_clk);
        i_cfg_index <= CFG_MAP_WIDTH_PX;
        i_cfg_data  <= CFG_DATA_W'(mw);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tile_size_q     = ts & ((1 << TS_W) - 1);
        tiles_per_row_q = tpr & ((1 << TPR_W) - 1);
        map_width_q     = mw & ((1 << MW_W) - 1);
        geometry_count++;
    endtask

    // one random beat: mostly writes and queries around the window, some noise
    task automatic send_random_item(output bit counted);
        int ets, roll, px, py, sx, sy, col, row, lin, reach;
        logic [CMD_W-1:0] cmd;
        box_beat_t b;
        ets = effective_tile();
        reach = (3 * ets < 48) ? 3 * ets : 48;
        roll = $urandom_range(0, 99);
        counted = 1'b1;
        if (roll < 25) begin
            // paint the window, mostly solid
            col = win_col + int'($urandom_range(0, 5));
            row = win_row + int'($urandom_range(0, 5));
            lin = row * tiles_per_row_q + col;
            if (col >= tiles_per_row_q || lin >= MAP_TILES)
                lin = $urandom_range(0, MAX_TILE_INDEX);
            b = make_beat(CMD_WRITE, $urandom, $urandom, $urandom, $urandom, lin,
                          $urandom_range(0, 99) < 65);
        end else if (roll < 30) begin
            // anything the fields allow, spare codes included
            cmd = $urandom_range(0, MAX_CMD_CODE);
            b = make_beat(cmd, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            counted = (cmd <= CMD_FALLS);
        end else begin
            cmd = CMD_RIGHT + $urandom_range(0, CMD_FALLS - CMD_RIGHT);
            // rare oversized boxes keep walk lengths down on average
            sx = ($urandom_range(0, 99) < 3) ? $urandom_range(0, MAX_SIZE)
                                             : 1 + int'($urandom_range(0, reach));
            sy = ($urandom_range(0, 99) < 3) ? $urandom_range(0, MAX_SIZE)
                                             : 1 + int'($urandom_range(0, reach));
            px = win_col * ets + int'($urandom_range(0, 7 * ets))
                 - int'($urandom_range(0, ets + 8));
            py = win_row * ets + int'($urandom_range(0, 7 * ets))
                 - int'($urandom_range(0, ets + 8));
            if ($urandom_range(0, 1) == 1) begin
                case (cmd)
                    // bottom edge lands in the first few pixels of a window row
                    CMD_DOWN: py = (win_row + int'($urandom_range(0, 5))) * ets - sy
                                   + int'($urandom_range(1, SNAP_REACH + 1));
                    // box resting just above a window row
                    CMD_FALLS: py = (win_row + int'($urandom_range(0, 5))) * ets - sy - 1
                                    + int'($urandom_range(0, ets - 1));
                    // right edge around the screen limit
                    CMD_RIGHT: px = map_width_q - sx + int'($urandom_range(0, 2)) - 1;
                    default: ;
                endcase
            end
            b = make_beat(cmd, clamp_pos(px), clamp_pos(py), sx, sy, $urandom, $urandom);
        end
        send_beat(b);
    endtask

    // one geometry setting followed by a block of random beats
    task automatic run_geometry_phase(input int phase, input int ts, input int tpr,
                                      input int mw);
        int ets, max_col, max_row, done;
        bit counted;
        drain_results();
        set_map_geometry(ts, tpr, mw);
        // sender light / receiver heavy, then swapped, then no idling at all
        if (phase < 4) begin
            tx_idle_pct = 11;
            rx_idle_pct = 48;
        end else if (phase < 8) begin
            tx_idle_pct = 48;
            rx_idle_pct = 11;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        // window stays inside the pixel range and, where possible, the store
        ets = effective_tile();
        max_col = 1400 / ets - 7;
        if (max_col > tiles_per_row_q - 6) max_col = tiles_per_row_q - 6;
        if (max_col < 0) max_col = 0;
        max_row = 1400 / ets - 7;
        if (max_row > (MAP_TILES - 1) / tiles_per_row_q - 6)
            max_row = (MAP_TILES - 1) / tiles_per_row_q - 6;
        if (max_row < 0) max_row = 0;
        win_col = $urandom_range(0, max_col);
        win_row = $urandom_range(0, max_row);
        done = 0;
        while (done < ITEMS_PER_PHASE) begin
            send_random_item(counted);
            if (counted) done++;
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset geometry: 16 px tiles, 64 per row, 1024 px wide
    task automatic test_directed_cases();
        send_beat(make_beat(CMD_UP,    0,     0,     1,   1,   0,    1'b0)); // empty map
        // writes carry extreme junk in the query fields
        send_beat(make_beat(CMD_WRITE, -2048, 2047,  511, 256, 0,    1'b1));
        send_beat(make_beat(CMD_WRITE, 2047,  -2048, 256, 511, 4095, 1'b1));
        send_beat(make_beat(CMD_WRITE, 0,     0,     1,   1,   131,  1'b1)); // row 2 col 3
        send_beat(make_beat(CMD_LEFT,  0,     0,     1,   1,   0,    1'b0)); // solid corner
        send_beat(make_beat(CMD_LEFT,  -1,    0,     1,   1,   0,    1'b0)); // left screen edge
        send_beat(make_beat(CMD_UP,    0,     -2048, 1,   1,   0,    1'b0)); // top screen edge
        send_beat(make_beat(CMD_UP,    0,     0,     1,   1,   0,    1'b0));
        send_beat(make_beat(CMD_RIGHT, 1023,  100,   1,   1,   0,    1'b0)); // right at limit
        send_beat(make_beat(CMD_RIGHT, 1024,  100,   1,   1,   0,    1'b0)); // one past
        send_beat(make_beat(CMD_RIGHT, 2047,  2047,  511, 511, 0,    1'b0));
        send_beat(make_beat(CMD_RIGHT, 1008,  1008,  16,  16,  0,    1'b0)); // last tile
        send_beat(make_beat(CMD_DOWN,  48,    18,    16,  16,  0,    1'b0)); // snaps to 16
        send_beat(make_beat(CMD_DOWN,  48,    21,    16,  16,  0,    1'b0)); // just out of reach
        send_beat(make_beat(CMD_DOWN,  48,    13,    16,  16,  0,    1'b0)); // empty row
        send_beat(make_beat(CMD_FALLS, 48,    15,    16,  16,  0,    1'b0)); // standing
        send_beat(make_beat(CMD_FALLS, 40,    15,    16,  16,  0,    1'b0)); // half over a gap
        send_beat(make_beat(CMD_LEFT,  0,     16,    0,   0,   0,    1'b0)); // empty row range
        send_beat(make_beat(CMD_FALLS, 2047,  2047,  511, 511, 0,    1'b0)); // off the map
        send_beat(make_beat(CMD_SPARE_LO, -2048, -2048, 0, 0,  4095, 1'b1));
        send_beat(make_beat(CMD_SPARE_HI, 2047,  2047,  511, 511, 0, 1'b0));
        send_beat(make_beat(CMD_WRITE, 0,     0,     0,   0,   0,    1'b0)); // clear corner
        send_beat(make_beat(CMD_LEFT,  0,     0,     1,   1,   0,    1'b0));
        send_beat(make_beat(CMD_DOWN,  -2048, -2048, 0,   0,   0,    1'b0)); // negative tiles
        send_beat(make_beat(CMD_UP,    0,     2047,  256, 256, 0,    1'b0)); // rows off the map
    endtask

    // smallest and largest tiles, widest and narrowest maps, zero tile size
    task automatic test_extreme_geometry();
        run_geometry_phase(0, 1, 4096, 4095);
        run_geometry_phase(1, 64, 1, 0);
        run_geometry_phase(2, 0, 64, 1024);
    endtask

    // random geometry, mostly narrow rows so the window lands inside the store
    task automatic test_random_geometry();
        int phase, tpr;
        for (phase = 3; phase < RAND_PHASES; phase++) begin
            tpr = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 128)
                                              : $urandom_range(1, MAP_TILES);
            run_geometry_phase(phase, $urandom_range(0, 64), tpr, $urandom_range(0, 4095));
        end
    endtask

    // ---------------------------------------------------------------
    // result checker and receiver stalls
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        box_answer_t want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            results_checked++;
            if (expected_answers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d with nothing owed: hit=%0b y=%0d",
                             results_checked, o_hit, o_new_pos_y);
            end else begin
                want = expected_answers.pop_front();
                if (o_hit !== want.hit || o_new_pos_y !== want.new_pos_y) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d mismatch: expected hit=%0b y=%0d, got hit=%0b y=%0d",
                                 results_checked, want.hit, want.new_pos_y, o_hit, o_new_pos_y);
                end
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // ---------------------------------------------------------------
    // run sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the block clears its map first and holds off beats until done
        test_directed_cases();
        test_extreme_geometry();
        test_random_geometry();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d beats (%0d tile writes) over %0d map geometries and 3 idle mixes",
                 beats_sent, writes_sent, geometry_count);
        $display("checked %0d answers: %0d hits, %0d down snaps, %0d mismatches",
                 results_checked, hits_predicted, snaps_predicted, mismatch_count);
        if (mismatch_count == 0 && expected_answers.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial begin
        repeat (RUN_LIMIT_CYCLES) @(posedge i_clk);
        $display("timeout with %0d answers still owed", expected_answers.size());
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/tmbc_pkg.sv
sv/tile_map_box_collision.sv
bench/tb_tile_map_box_collision.sv
